### rtl/core/bbvp_pkg.sv
// ---------------------------------------------------------------------------
// bbvp_pkg
// Shared types and constants of the basic-block vector profiler.
// ---------------------------------------------------------------------------
package bbvp_pkg;

	localparam int TW  = 3;   // thread field
	localparam int BW  = 10;  // block field
	localparam int IW  = 16;  // instruction count field
	localparam int CW  = 32;  // visit count
	localparam int SW  = 41;  // region instruction total
	localparam int RW  = 32;  // region index
	localparam int PAW = 4;   // APB address
	localparam int PDW = 64;  // APB data

	localparam logic [SW-1:0] THRESH_RESET = SW'(100000000);

	typedef enum logic {
		FN_EVENT = 1'b0,
		FN_FLUSH = 1'b1
	} func_t;

	// registers sit at 8-byte strides; bit 3 of paddr picks one
	typedef enum logic {
		REG_ENABLE = 1'b0,
		REG_THRESH = 1'b1
	} reg_sel_t;

	typedef struct packed {
		func_t           func;
		logic [TW-1:0]   thread;
		logic [BW-1:0]   block;
		logic [IW-1:0]   insts;
	} req_t;

	// visit table entry: count is live only while tag matches the region index
	typedef struct packed {
		logic [RW-1:0]   tag;
		logic [CW-1:0]   count;
	} entry_t;

	typedef struct packed {
		logic            event_valid;
		logic [TW-1:0]   out_thread;
		logic [BW-1:0]   out_block;
		logic [CW-1:0]   visits;
		logic [SW-1:0]   stamp;
		logic [RW-1:0]   region_index;
		logic            region_closed;
		logic [SW-1:0]   region_total;
	} result_t;

endpackage

### rtl/core/bbvp_visit_ram.sv
// ---------------------------------------------------------------------------
// bbvp_visit_ram
// Visit table memory: one write and one registered read port, plus a
// zeroing sweep over all entries after reset.
// ---------------------------------------------------------------------------
module bbvp_visit_ram #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ren,
	input  logic [AW-1:0]       raddr,
	output bbvp_pkg::entry_t    rdata,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  bbvp_pkg::entry_t    wr_data,
	output logic                clearing
);
	import bbvp_pkg::*;

	entry_t          mem [DEPTH];
	entry_t          rdata_q;
	logic            clearing_q;
	logic [AW-1:0]   clr_addr_q;
	logic            we;
	logic [AW-1:0]   wa;
	entry_t          wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		we = clearing_q || wr_en;
		wa = clearing_q ? clr_addr_q : wr_addr;
		wd = clearing_q ? entry_t'('0) : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (ren) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

### rtl/core/bbvp_update.sv
// ---------------------------------------------------------------------------
// bbvp_update
// Read-modify-write stage: merges the table read with the last write,
// bumps the visit count, keeps the region total and index.
// ---------------------------------------------------------------------------
module bbvp_update #(
	parameter int AW = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  bbvp_pkg::req_t              req,
	input  logic [AW-1:0]               addr,
	input  bbvp_pkg::entry_t            rd_entry,
	input  logic [bbvp_pkg::SW-1:0]     threshold,
	input  logic                        adv,
	output logic                        s1_busy,
	output logic                        commit,
	output bbvp_pkg::result_t           res,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output bbvp_pkg::entry_t            wr_data
);
	import bbvp_pkg::*;

	logic            s1_valid_q;
	req_t            req_s1;
	logic [AW-1:0]   addr_s1;
	logic            fwd_ok_s1;
	logic [AW-1:0]   fwd_addr_q;
	entry_t          fwd_entry_q;
	logic [RW-1:0]   region_q;
	logic [SW-1:0]   region_insts_q;

	logic            ev;
	logic            flush;
	entry_t          base_entry;
	logic [CW-1:0]   base;
	logic [CW-1:0]   vnew;
	logic [SW:0]     sum;
	logic [SW-1:0]   total;
	logic            closes;

	always_comb begin
		ev    = (req_s1.func == FN_EVENT);
		flush = (req_s1.func == FN_FLUSH);
		// previous word wrote this entry on the edge we read it
		base_entry = (fwd_ok_s1 && (fwd_addr_q == addr_s1)) ? fwd_entry_q : rd_entry;
		base  = (base_entry.tag == region_q) ? base_entry.count : '0;
		vnew  = (base == '1) ? base : base + CW'(1);
		sum   = {1'b0, region_insts_q} + {{(SW + 1 - IW){1'b0}}, req_s1.insts};
		total = sum[SW] ? '1 : sum[SW-1:0];
		closes = flush || (total >= threshold);

		commit = s1_valid_q && adv;

		res.event_valid   = ev;
		res.out_thread    = ev ? req_s1.thread : '0;
		res.out_block     = ev ? req_s1.block : '0;
		res.visits        = ev ? vnew : '0;
		res.stamp         = ev ? total : '0;
		res.region_index  = region_q;
		res.region_closed = closes;
		res.region_total  = flush ? region_insts_q : (closes ? total : '0);

		wr_en        = commit && ev;
		wr_addr      = addr_s1;
		wr_data.tag   = region_q;
		wr_data.count = vnew;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q     <= 1'b0;
			fwd_ok_s1      <= 1'b0;
			region_q       <= '0;
			region_insts_q <= '0;
		end else begin
			if (take) begin
				s1_valid_q <= 1'b1;
				fwd_ok_s1  <= wr_en;
			end else if (commit) begin
				s1_valid_q <= 1'b0;
			end
			if (commit) begin
				if (closes) begin
					region_q       <= region_q + RW'(1);
					region_insts_q <= '0;
				end else if (ev) begin
					region_insts_q <= total;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1  <= req;
			addr_s1 <= addr;
		end
		if (wr_en) begin
			fwd_addr_q  <= wr_addr;
			fwd_entry_q <= wr_data;
		end
	end

	assign s1_busy = s1_valid_q;

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (!s1_valid_q || adv))
		else $error("new word loaded over an uncommitted one");

	a_close_advances: assert property (@(posedge clk) disable iff (!arst_n)
		commit && closes |=> (region_q == $past(region_q) + RW'(1)) && (region_insts_q == '0))
		else $error("region close did not advance index and clear total");

	a_open_below_thresh: assert property (@(posedge clk) disable iff (!arst_n)
		commit && ev && !closes |=>
			(region_insts_q < $past(threshold)) && (region_insts_q >= $past(region_insts_q)))
		else $error("open region total out of order");
`endif

endmodule

### rtl/core/basic_block_vector_profiler_top.sv
// ---------------------------------------------------------------------------
// basic_block_vector_profiler_top
// Basic-block vector profiler: per thread/block visit counts and running
// region instruction totals, with region close on threshold or flush.
// ---------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  --------------------------------------------
//  in        in_valid / in_stall    func, thread_index, block_id, block_insts
//  out       out_valid / out_stall  event_valid, out_thread, out_block, visits,
//                                   stamp, region_index, region_closed,
//                                   region_total
//  cfg       APB (pready tied 1)    0x0 enable, 0x8 region_threshold
//
//  One word per cycle sustained while the output is not stalled. A word is read
//  from the visit table on the edge that accepts it, then updated and written
//  back as its result is loaded into the output register, when that can take it.
//  Back-to-back hits on the same entry are forwarded from the last write.
//  After reset the visit table is zeroed, one entry a cycle: in_stall stays
//  high while all THREADS*BLOCKS entries (8192 by default) are swept.
//  Region clears need no sweep: entries carry the region index they were
//  written in and read as zero in any other region.
//  in_stall rises only during the clearing sweep or when the update stage holds
//  a word the stalled output register cannot take.
//
module basic_block_vector_profiler_top #(
	parameter int THREADS = 8,
	parameter int BLOCKS  = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bbvp_pkg::PAW-1:0]    paddr,
	input  logic [bbvp_pkg::PDW-1:0]    pwdata,
	output logic [bbvp_pkg::PDW-1:0]    prdata,
	output logic                        pready,
	// input words
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [bbvp_pkg::TW-1:0]     thread_index,
	input  logic [bbvp_pkg::BW-1:0]     block_id,
	input  logic [bbvp_pkg::IW-1:0]     block_insts,
	// result words
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        event_valid,
	output logic [bbvp_pkg::TW-1:0]     out_thread,
	output logic [bbvp_pkg::BW-1:0]     out_block,
	output logic [bbvp_pkg::CW-1:0]     visits,
	output logic [bbvp_pkg::SW-1:0]     stamp,
	output logic [bbvp_pkg::RW-1:0]     region_index,
	output logic                        region_closed,
	output logic [bbvp_pkg::SW-1:0]     region_total
);
	import bbvp_pkg::*;

	localparam int DEPTH = THREADS * BLOCKS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// configuration registers
	logic            enable_q;
	logic [SW-1:0]   threshold_q;
	logic            cfg_wr;

	// input side
	logic            accept;
	logic            in_range;
	logic            take;
	req_t            req;
	logic [AW-1:0]   rd_addr;

	// update stage / memory
	logic            clearing;
	entry_t          rd_entry;
	logic            s1_busy;
	logic            commit;
	logic            adv;
	result_t         res;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;

	// output register
	logic            out_valid_q;
	result_t         out_q;

	// ---- APB ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			threshold_q <= THRESH_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel_t'(paddr[3]))
				REG_ENABLE: enable_q    <= pwdata[0];
				REG_THRESH: threshold_q <= pwdata[SW-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel_t'(paddr[3]))
			REG_ENABLE: prdata = {{(PDW - 1){1'b0}}, enable_q};
			REG_THRESH: prdata = {{(PDW - SW){1'b0}}, threshold_q};
			default:    prdata = '0;
		endcase
	end

	// ---- input side ----
	// flushes act regardless of enable; disabled or out-of-range events
	// are accepted and dropped without a result
	always_comb begin
		adv      = !out_valid_q || !out_stall;
		in_stall = clearing || (s1_busy && !adv);
		accept   = in_valid && !in_stall;
		in_range = (32'(thread_index) < THREADS) && (32'(block_id) < BLOCKS);
		take     = accept && ((func_t'(func) == FN_FLUSH) || (enable_q && in_range));

		req.func   = func_t'(func);
		req.thread = thread_index;
		req.block  = block_id;
		req.insts  = block_insts;
		rd_addr    = AW'(int'(thread_index) * BLOCKS + int'(block_id));
	end

	bbvp_visit_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.ren      (take),
		.raddr    (rd_addr),
		.rdata    (rd_entry),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.clearing (clearing)
	);

	bbvp_update #(
		.AW (AW)
	) u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.req       (req),
		.addr      (rd_addr),
		.rd_entry  (rd_entry),
		.threshold (threshold_q),
		.adv       (adv),
		.s1_busy   (s1_busy),
		.commit    (commit),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_valid   = out_q.event_valid;
	assign out_thread    = out_q.out_thread;
	assign out_block     = out_q.out_block;
	assign visits        = out_q.visits;
	assign stamp         = out_q.stamp;
	assign region_index  = out_q.region_index;
	assign region_closed = out_q.region_closed;
	assign region_total  = out_q.region_total;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the basic-block vector profiler. A directed plan of
// register writes and words covers the edge cases, then random phases run
// under several enable/threshold settings with random idling on both
// channels, a quiet stretch and one long output hold-off. Every result word
// is checked field by field against a typed word or the in-bench profiler model.
// ---------------------------------------------------------------------------
module tb;
	import bbvp_pkg::*;

	localparam int N_THREADS = 8;
	localparam int N_BLOCKS  = 1024;
	localparam logic [PDW-1:0] THRESH_MAX = {{(PDW-SW){1'b0}}, {SW{1'b1}}};

	// how a plan row is checked: by the model, by a typed word, or no result
	typedef enum logic [1:0] {CHK_MODEL, CHK_TYPED, CHK_NONE} check_t;
	typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t       kind;
		reg_sel_t        sel;
		logic [PDW-1:0]  val;
		req_t            w;
		check_t          chk;
		result_t         want;
	} plan_row_t;

	logic            clk, arst_n;
	logic            psel, penable, pwrite, pready;
	logic [PAW-1:0]  paddr;
	logic [PDW-1:0]  pwdata, prdata;
	logic            in_valid, in_stall;
	func_t           func;
	logic [TW-1:0]   thread_index;
	logic [BW-1:0]   block_id;
	logic [IW-1:0]   block_insts;
	logic            out_valid, out_stall;
	logic            event_valid, region_closed;
	logic [TW-1:0]   out_thread;
	logic [BW-1:0]   out_block;
	logic [CW-1:0]   visits;
	logic [SW-1:0]   stamp, region_total;
	logic [RW-1:0]   region_index;

	// profiler model state and its copy of the registers
	logic [CW-1:0]   visit_cnt [int unsigned];
	logic [SW-1:0]   region_sum;
	logic [RW-1:0]   region_no;
	logic            cfg_enable;
	logic [SW-1:0]   cfg_thresh;

	result_t         pending [$];     // profile words still owed by the DUT
	plan_row_t       plan [$];
	int              bad_words;
	bit              gaps_on, stalls_on, hold_req;

	basic_block_vector_profiler_top #(
		.THREADS(N_THREADS),
		.BLOCKS (N_BLOCKS)
	) DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.thread_index(thread_index), .block_id(block_id), .block_insts(block_insts),
		.out_valid(out_valid), .out_stall(out_stall), .event_valid(event_valid),
		.out_thread(out_thread), .out_block(out_block), .visits(visits),
		.stamp(stamp), .region_index(region_index), .region_closed(region_closed),
		.region_total(region_total)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit: ends the run as a watchdog should the stimulus never finish.
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	// Ends the current region: index advances, total and visit table clear.
	function automatic void close_region();
		region_no = region_no + 1'b1;
		region_sum = '0;
		visit_cnt.delete();
	endfunction

	// Profiles one accepted word. Returns 1 when the word yields a result.
	function automatic bit profile_word(input req_t w, output result_t r);
		logic [SW:0]    sum;
		int unsigned    key;
		logic [CW-1:0]  v;
		r = '0;
		r.region_index = region_no;
		// flush closes the region whether counting is on or not
		if (w.func == FN_FLUSH) begin
			r.region_closed = 1'b1;
			r.region_total = region_sum;
			close_region();
			return 1'b1;
		end
		if (!cfg_enable)
			return 1'b0;
		// pairs outside the table are dropped; unreachable at 8 x 1024
		if (w.thread >= N_THREADS || w.block >= N_BLOCKS)
			return 1'b0;
		// running total saturates at all ones
		sum = {1'b0, region_sum} + w.insts;
		region_sum = sum[SW] ? '1 : sum[SW-1:0];
		key = w.thread * N_BLOCKS + w.block;
		v = visit_cnt.exists(key) ? visit_cnt[key] : '0;
		if (v != '1)
			v = v + 1'b1;
		visit_cnt[key] = v;
		r.event_valid = 1'b1;
		r.out_thread = w.thread;
		r.out_block = w.block;
		r.visits = v;
		r.stamp = region_sum;
		// a zero threshold closes on every event
		if (region_sum >= cfg_thresh) begin
			r.region_closed = 1'b1;
			r.region_total = region_sum;
			close_region();
		end
		return 1'b1;
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("ev=%0d thr=%0d blk=%0d visits=%0d stamp=%0d region=%0d closed=%0d total=%0d",
			r.event_valid, r.out_thread, r.out_block, r.visits, r.stamp,
			r.region_index, r.region_closed, r.region_total);
	endfunction

	function automatic plan_row_t word_row(input func_t f, input int t, input int b,
			input int n, input check_t c, input result_t want);
		plan_row_t p;
		p.kind = ROW_WORD;
		p.sel = REG_ENABLE;
		p.val = '0;
		p.w.func = f;
		p.w.thread = TW'(t);
		p.w.block = BW'(b);
		p.w.insts = IW'(n);
		p.chk = c;
		p.want = want;
		return p;
	endfunction

	function automatic plan_row_t reg_row(input reg_sel_t sel, input logic [PDW-1:0] val);
		plan_row_t p;
		p = word_row(FN_EVENT, 0, 0, 0, CHK_NONE, '0);
		p.kind = ROW_REG;
		p.sel = sel;
		p.val = val;
		return p;
	endfunction

	// Offers one word, starting and ending at a falling edge. Random idle
	// cycles go in front, with junk on the payload while valid is low.
	task automatic send_word(input req_t w, input check_t chk, input result_t typed);
		result_t r;
		bit      has;
		while (gaps_on && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			func <= func_t'($urandom_range(0, 1));
			thread_index <= TW'($urandom);
			block_id <= BW'($urandom);
			block_insts <= IW'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= w.func;
		thread_index <= w.thread;
		block_id <= w.block;
		block_insts <= w.insts;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		has = profile_word(w, r);
		if (chk == CHK_TYPED)
			pending.push_back(typed);
		else if (chk == CHK_MODEL && has)
			pending.push_back(r);
		@(negedge clk);
	endtask

	// Waits for every owed word, then lets ignored words in flight drain.
	task automatic settle();
		while (pending.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// APB write then read-back of one register; starts and ends at a falling edge.
	task automatic write_reg(input reg_sel_t sel, input logic [PDW-1:0] val);
		logic [PDW-1:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (sel == REG_ENABLE)
			cfg_enable = val[0];
		else
			cfg_thresh = val[SW-1:0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		want = (sel == REG_ENABLE) ? PDW'(cfg_enable) : PDW'(cfg_thresh);
		if (prdata !== want) begin
			bad_words++;
			if (bad_words <= 10)
				$display("register %s read back %h, want %h", sel.name(), prdata, want);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Result monitor: every accepted word is matched to the oldest owed one.
	initial begin : monitor
		result_t got, want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = {event_valid, out_thread, out_block, visits, stamp,
					region_index, region_closed, region_total};
				if (pending.size() == 0) begin
					bad_words++;
					if (bad_words <= 10)
						$display("unowed word: %s", show(got));
				end else begin
					want = pending.pop_front();
					if (got.event_valid !== want.event_valid ||
							got.out_thread !== want.out_thread ||
							got.out_block !== want.out_block ||
							got.visits !== want.visits ||
							got.stamp !== want.stamp ||
							got.region_index !== want.region_index ||
							got.region_closed !== want.region_closed ||
							got.region_total !== want.region_total) begin
						bad_words++;
						if (bad_words <= 10)
							$display("word mismatch\n  want %s\n  got  %s",
								show(want), show(got));
					end
				end
			end
		end
	end

	// Output stall: random idling, or a long hold-off counted here on request.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 150;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= stalls_on && ($urandom_range(0, 99) < 29);
			end
		end
	end

	initial begin : stimulus
		req_t           w;
		logic [PDW-1:0] thr_val;
		int             n_words;
		bit             hot;

		// every input known from time zero
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = FN_EVENT;
		thread_index = '0;
		block_id = '0;
		block_insts = '0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		hold_req = 1'b0;
		bad_words = 0;

		// model reset state
		visit_cnt.delete();
		region_sum = '0;
		region_no = '0;
		cfg_enable = 1'b0;
		cfg_thresh = THRESH_RESET;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed plan. Typed words are the ones readable at a glance:
		// a flush off an empty total, first visits at the field extremes, a
		// back-to-back second visit, and a close under a zero threshold.
		plan.push_back(word_row(FN_EVENT, 7, 1023, 16'hFFFF, CHK_NONE, '0));
		plan.push_back(word_row(FN_FLUSH, 5, 'h155, 'hAAAA, CHK_TYPED,
			result_t'{1'b0, 3'd0, 10'd0, 32'd0, 41'd0, 32'd0, 1'b1, 41'd0}));
		plan.push_back(reg_row(REG_ENABLE, 64'd1));
		plan.push_back(word_row(FN_EVENT, 0, 0, 0, CHK_TYPED,
			result_t'{1'b1, 3'd0, 10'd0, 32'd1, 41'd0, 32'd1, 1'b0, 41'd0}));
		plan.push_back(word_row(FN_EVENT, 7, 1023, 16'hFFFF, CHK_TYPED,
			result_t'{1'b1, 3'd7, 10'd1023, 32'd1, 41'd65535, 32'd1, 1'b0, 41'd0}));
		// same entry back to back: exercises the update forwarding
		plan.push_back(word_row(FN_EVENT, 7, 1023, 1, CHK_TYPED,
			result_t'{1'b1, 3'd7, 10'd1023, 32'd2, 41'd65536, 32'd1, 1'b0, 41'd0}));
		plan.push_back(word_row(FN_EVENT, 2, 'h2AA, 'h5555, CHK_MODEL, '0));
		plan.push_back(word_row(FN_EVENT, 7, 1023, 3, CHK_MODEL, '0));
		plan.push_back(word_row(FN_FLUSH, 0, 0, 0, CHK_MODEL, '0));
		// zero threshold: every event closes its own region
		plan.push_back(reg_row(REG_THRESH, 64'd0));
		plan.push_back(word_row(FN_EVENT, 3, 512, 0, CHK_TYPED,
			result_t'{1'b1, 3'd3, 10'd512, 32'd1, 41'd0, 32'd2, 1'b1, 41'd0}));
		plan.push_back(word_row(FN_EVENT, 3, 512, 0, CHK_MODEL, '0));
		plan.push_back(reg_row(REG_THRESH, 64'd1));
		plan.push_back(word_row(FN_EVENT, 4, 1, 0, CHK_MODEL, '0));
		plan.push_back(word_row(FN_EVENT, 4, 1, 1, CHK_MODEL, '0));
		plan.push_back(reg_row(REG_THRESH, THRESH_MAX));
		plan.push_back(word_row(FN_EVENT, 6, 'h3FF, 16'hFFFF, CHK_MODEL, '0));
		plan.push_back(word_row(FN_EVENT, 6, 'h3FF, 16'hFFFF, CHK_MODEL, '0));
		// counting off: events vanish, flush still closes
		plan.push_back(reg_row(REG_ENABLE, 64'd0));
		plan.push_back(word_row(FN_EVENT, 1, 5, 10, CHK_NONE, '0));
		plan.push_back(word_row(FN_FLUSH, 1, 5, 10, CHK_MODEL, '0));
		plan.push_back(reg_row(REG_ENABLE, 64'd1));
		plan.push_back(reg_row(REG_THRESH, PDW'(THRESH_RESET)));
		plan.push_back(word_row(FN_EVENT, 1, 5, 10, CHK_MODEL, '0));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				in_valid <= 1'b0;
				settle();
				write_reg(plan[i].sel, plan[i].val);
			end else begin
				send_word(plan[i].w, plan[i].chk, plan[i].want);
			end
		end

		// Random phases, each with its own setting:
		//   0 mid threshold, 1 tiny threshold with a quiet stretch,
		//   2 no threshold close plus the long hold-off, 3 counting off,
		//   4 small threshold.
		for (int ph = 0; ph < 5; ph++) begin
			in_valid <= 1'b0;
			settle();
			case (ph)
				0: thr_val = PDW'($urandom_range(20000, 200000));
				1: thr_val = PDW'($urandom_range(1, 3000));
				2: thr_val = THRESH_MAX;
				3: thr_val = PDW'($urandom_range(1, 1000));
				default: thr_val = PDW'($urandom_range(1000, 60000));
			endcase
			write_reg(REG_ENABLE, (ph == 3) ? 64'd0 : 64'd1);
			write_reg(REG_THRESH, thr_val);
			n_words = (ph == 3) ? 40 : 130;
			for (int k = 0; k < n_words; k++) begin
				gaps_on = !(ph == 1 && k < 60);
				stalls_on = gaps_on;
				if (ph == 2 && k == 20)
					hold_req = 1'b1;
				// a few hot pairs so visit counts climb past one
				hot = $urandom_range(0, 99) < 60;
				w.func = ($urandom_range(0, 99) < 4) ? FN_FLUSH : FN_EVENT;
				w.thread = hot ? TW'($urandom_range(0, 1)) : TW'($urandom);
				w.block = hot ? BW'($urandom_range(0, 3)) : BW'($urandom);
				case ($urandom_range(0, 9))
					0: w.insts = '0;
					1: w.insts = '1;
					2, 3: w.insts = IW'($urandom);
					default: w.insts = IW'($urandom_range(0, 300));
				endcase
				send_word(w, CHK_MODEL, '0);
			end
		end

		in_valid <= 1'b0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (bad_words == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### basic_block_vector_profiler_top.f
rtl/core/bbvp_pkg.sv
rtl/core/bbvp_visit_ram.sv
rtl/core/bbvp_update.sv
rtl/core/basic_block_vector_profiler_top.sv
dv/tb.sv
